// ===== design/tkcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-key chord detector package
// Shared types and constants for the chord detector and its parts.
// ----------------------------------------------------------------------------
package tkcd_pkg;

  // Width of the chord window register and of the timestamp
  localparam int unsigned WIN_W = 16;
  localparam int unsigned TS_W  = 32;

  // Reset value of the chord window in ms
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(80);

  // Which key waits for the chord window to close
  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_A    = 2'd1,
    PEND_B    = 2'd2
  } pend_t;

  // One poll tick
  typedef struct packed {
    logic            key_a_down;
    logic            key_b_down;
    logic [TS_W-1:0] now_ms;
  } in_t;

  // One result per tick
  typedef struct packed {
    logic toggle_page;
    logic a_press;
    logic a_release;
    logic b_press;
    logic b_release;
  } out_t;

  // Detector state carried from tick to tick
  typedef struct packed {
    pend_t           pending_key;
    logic [TS_W-1:0] pending_start;
    logic            a_active;
    logic            b_active;
    logic            chord_latched;
    logic            prev_a_down;
    logic            prev_b_down;
  } state_t;

endpackage

// ===== design/tkcd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chord detector step logic
// Combinational next state and result for one poll tick.
// ----------------------------------------------------------------------------
module tkcd_core (
  input  tkcd_pkg::state_t               st,
  input  tkcd_pkg::in_t                  item,
  input  logic [tkcd_pkg::WIN_W-1:0]     window,
  output tkcd_pkg::state_t               st_nxt,
  output tkcd_pkg::out_t                 res
);

  logic                      a_rise;
  logic                      b_rise;
  logic                      a_fall;
  logic                      b_fall;
  logic [tkcd_pkg::TS_W-1:0] elapsed;
  logic [tkcd_pkg::TS_W-1:0] start_sel;
  logic                      held;
  logic                      is_a;
  tkcd_pkg::pend_t           pend_cur;
  tkcd_pkg::pend_t           pend;

  // Edges against the previous levels
  assign a_rise = item.key_a_down & ~st.prev_a_down;
  assign b_rise = item.key_b_down & ~st.prev_b_down;
  assign a_fall = ~item.key_a_down & st.prev_a_down;
  assign b_fall = ~item.key_b_down & st.prev_b_down;

  always_comb begin
    st_nxt             = st;
    res                = '0;
    st_nxt.prev_a_down = item.key_a_down;
    st_nxt.prev_b_down = item.key_b_down;

    // Normalize the pending code; an unknown code means none
    case (st.pending_key)
      tkcd_pkg::PEND_A: pend_cur = tkcd_pkg::PEND_A;
      tkcd_pkg::PEND_B: pend_cur = tkcd_pkg::PEND_B;
      default:          pend_cur = tkcd_pkg::PEND_NONE;
    endcase

    // Start a fresh pending press, A wins over B
    pend      = pend_cur;
    start_sel = st.pending_start;
    if (pend == tkcd_pkg::PEND_NONE) begin
      if (a_rise) begin
        pend      = tkcd_pkg::PEND_A;
        start_sel = item.now_ms;
      end else if (b_rise) begin
        pend      = tkcd_pkg::PEND_B;
        start_sel = item.now_ms;
      end
    end
    is_a = (pend == tkcd_pkg::PEND_A);
    held = is_a ? item.key_a_down : item.key_b_down;

    // Elapsed time since the pending press, wrapping modulo 2^32
    elapsed = item.now_ms - start_sel;

    if (item.key_a_down && item.key_b_down) begin
      // Chord: release actions, drop pending press, fire one toggle
      st_nxt.pending_key = tkcd_pkg::PEND_NONE;
      if (st.a_active) begin
        res.a_release   = 1'b1;
        st_nxt.a_active = 1'b0;
      end
      if (st.b_active) begin
        res.b_release   = 1'b1;
        st_nxt.b_active = 1'b0;
      end
      if (!st.chord_latched) begin
        res.toggle_page      = 1'b1;
        st_nxt.chord_latched = 1'b1;
      end
    end else if (st.chord_latched) begin
      // Ignore keys until both are up
      st_nxt.pending_key = pend_cur;
      if (!item.key_a_down && !item.key_b_down) begin
        st_nxt.chord_latched = 1'b0;
      end
    end else begin
      st_nxt.pending_key   = pend;
      st_nxt.pending_start = start_sel;
      if (pend != tkcd_pkg::PEND_NONE) begin
        if (!held) begin
          // Released while still pending: press and release together
          if (is_a) begin
            res.a_press   = 1'b1;
            res.a_release = 1'b1;
          end else begin
            res.b_press   = 1'b1;
            res.b_release = 1'b1;
          end
          st_nxt.pending_key = tkcd_pkg::PEND_NONE;
        end else if (elapsed >= {{(tkcd_pkg::TS_W-tkcd_pkg::WIN_W){1'b0}}, window}) begin
          // Window closed while held: start the action
          if (is_a) begin
            res.a_press     = 1'b1;
            st_nxt.a_active = 1'b1;
          end else begin
            res.b_press     = 1'b1;
            st_nxt.b_active = 1'b1;
          end
          st_nxt.pending_key = tkcd_pkg::PEND_NONE;
        end
      end
      // End an active action on its release edge
      if (st_nxt.a_active && a_fall) begin
        res.a_release   = 1'b1;
        st_nxt.a_active = 1'b0;
      end
      if (st_nxt.b_active && b_fall) begin
        res.b_release   = 1'b1;
        st_nxt.b_active = 1'b0;
      end
    end
  end

endmodule

// ===== design/two_key_chord_detector_top.sv =====
`timescale 1ns / 1ps
// A result is registered into the output register, or into the skid stage while the output is stalled.
// Throughput: one tick per cycle while in_stall is low; the step is combinational logic on the state register.
// A skid stage behind the output register keeps input flowing for one stalled result.
// Reset (rst_n low, synchronous): state cleared, window back to 80 ms, no result held.
// ----------------------------------------------------------------------------
// Two-key chord detector top level
// Turns polled levels of two keys into single-key actions and a chord toggle.
// ----------------------------------------------------------------------------
module two_key_chord_detector_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  tkcd_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output tkcd_pkg::out_t               out_data,
  input  logic                         cfg_wr_en,
  input  logic [tkcd_pkg::WIN_W-1:0]   cfg_wr_data
);

  tkcd_pkg::state_t             st_r;
  tkcd_pkg::state_t             st_nxt;
  tkcd_pkg::out_t               res;
  tkcd_pkg::out_t               out_data_r;
  tkcd_pkg::out_t               skid_data_r;
  logic                         out_valid_r;
  logic                         skid_valid_r;
  logic [tkcd_pkg::WIN_W-1:0]   window_r;
  logic                         in_xfer;
  logic                         out_xfer;

  assign in_stall  = skid_valid_r;
  assign in_xfer   = in_valid & ~skid_valid_r;
  assign out_xfer  = out_valid_r & ~out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tkcd_core u_core (
    .st     (st_r),
    .item   (in_data),
    .window (window_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // Hold the chord window register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= tkcd_pkg::WIN_RESET;
    end else if (cfg_wr_en) begin
      window_r <= cfg_wr_data;
    end
  end

  // Advance the detector state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (in_xfer) begin
      if (out_valid_r && !out_xfer) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_xfer) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (out_valid_r && !out_xfer) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end else if (out_xfer && skid_valid_r) begin
      out_data_r <= skid_data_r;
    end
  end

endmodule

// ===== design/tkcd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chord detector port checker
// Watches the top level's ports, flags stalled results that are dropped or change, and impossible result patterns.
// ----------------------------------------------------------------------------
module tkcd_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_stall,
  input tkcd_pkg::out_t out_data
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // A chord tick never starts a single-key action
  a_no_press_on_chord: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.toggle_page |-> !out_data.a_press && !out_data.b_press)
    else $error("press reported with chord toggle");

  // At most one key starts an action per tick
  a_one_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.a_press && out_data.b_press))
    else $error("both keys pressed in one result");

endmodule

bind two_key_chord_detector_top tkcd_checker u_tkcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/two_key_chord_detector_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-key chord detector testbench
// Feeds polled key levels and timestamps through the valid/stall input channel
// and compares every result against an in-bench prediction of the detector.
// Runs directed ticks, then random key walks, under several chord windows and
// idle patterns, including a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module two_key_chord_detector_top_tb;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  tkcd_pkg::in_t              in_data;
  logic                       out_valid;
  logic                       out_stall;
  tkcd_pkg::out_t             out_data;
  logic                       cfg_wr_en;
  logic [tkcd_pkg::WIN_W-1:0] cfg_wr_data;

  two_key_chord_detector_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Ticks waiting to be offered and actions waiting to come out
  tkcd_pkg::in_t  poll_ticks[$];
  tkcd_pkg::out_t expected_actions[$];
  int             error_count = 0;

  // Idle rates in percent, long hold-off request
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   pressure_armed = 0;
  bit   hold_done = 0;
  int   hold_left = 0;
  int   taken_count = 0;
  int   seen_count = 0;

  // Predicted detector state
  logic [tkcd_pkg::WIN_W-1:0] win_ms = tkcd_pkg::WIN_RESET;
  tkcd_pkg::pend_t            wait_key = tkcd_pkg::PEND_NONE;
  logic [tkcd_pkg::TS_W-1:0]  wait_since = '0;
  logic                       a_held_act = 1'b0;
  logic                       b_held_act = 1'b0;
  logic                       chord_on = 1'b0;
  logic                       last_a = 1'b0;
  logic                       last_b = 1'b0;

  // Stimulus generator levels and clock
  logic                       gen_a = 1'b0;
  logic                       gen_b = 1'b0;
  logic [tkcd_pkg::TS_W-1:0]  gen_now = '0;

  // Advance the predicted state by one poll tick and return its actions
  function automatic tkcd_pkg::out_t predict_actions(tkcd_pkg::in_t tick);
    tkcd_pkg::out_t            res;
    logic                      a, b, a_rise, b_rise, a_fall, b_fall, held;
    logic [tkcd_pkg::TS_W-1:0] elapsed;
    res    = '0;
    a      = tick.key_a_down;
    b      = tick.key_b_down;
    a_rise = a & ~last_a;
    b_rise = b & ~last_b;
    a_fall = ~a & last_a;
    b_fall = ~b & last_b;
    last_a = a;
    last_b = b;
    if (a && b) begin
      // Chord: drop any single action, fire one toggle
      wait_key = tkcd_pkg::PEND_NONE;
      if (a_held_act) begin
        res.a_release = 1'b1;
        a_held_act = 1'b0;
      end
      if (b_held_act) begin
        res.b_release = 1'b1;
        b_held_act = 1'b0;
      end
      if (!chord_on) begin
        res.toggle_page = 1'b1;
        chord_on = 1'b1;
      end
    end else if (chord_on) begin
      if (!a && !b) chord_on = 1'b0;
    end else begin
      // Start a pending press, A first
      if (wait_key == tkcd_pkg::PEND_NONE) begin
        if (a_rise) begin
          wait_key   = tkcd_pkg::PEND_A;
          wait_since = tick.now_ms;
        end else if (b_rise) begin
          wait_key   = tkcd_pkg::PEND_B;
          wait_since = tick.now_ms;
        end
      end
      // Resolve the pending press as a tap or a hold
      if (wait_key != tkcd_pkg::PEND_NONE) begin
        held    = (wait_key == tkcd_pkg::PEND_A) ? a : b;
        elapsed = tick.now_ms - wait_since;
        if (!held) begin
          if (wait_key == tkcd_pkg::PEND_A) begin
            res.a_press   = 1'b1;
            res.a_release = 1'b1;
          end else begin
            res.b_press   = 1'b1;
            res.b_release = 1'b1;
          end
          wait_key = tkcd_pkg::PEND_NONE;
        end else if (elapsed >= tkcd_pkg::TS_W'(win_ms)) begin
          if (wait_key == tkcd_pkg::PEND_A) begin
            res.a_press = 1'b1;
            a_held_act  = 1'b1;
          end else begin
            res.b_press = 1'b1;
            b_held_act  = 1'b1;
          end
          wait_key = tkcd_pkg::PEND_NONE;
        end
      end
      if (a_held_act && a_fall) begin
        res.a_release = 1'b1;
        a_held_act = 1'b0;
      end
      if (b_held_act && b_fall) begin
        res.b_release = 1'b1;
        b_held_act = 1'b0;
      end
    end
    return res;
  endfunction

  task automatic check_field(string name, logic exp_bit, logic act_bit);
    if (exp_bit !== act_bit) begin
      $error("%s: expected %0b, got %0b", name, exp_bit, act_bit);
      error_count++;
    end
  endtask

  task automatic push_tick(logic a, logic b, logic [tkcd_pkg::TS_W-1:0] stamp);
    tkcd_pkg::in_t t;
    t.key_a_down = a;
    t.key_b_down = b;
    t.now_ms     = stamp;
    gen_a   = a;
    gen_b   = b;
    gen_now = stamp;
    poll_ticks.push_back(t);
  endtask

  // Random walk of key levels with time steps scaled to the chord window
  task automatic push_random_ticks(int count, int unsigned w);
    int                        r;
    logic                      a, b;
    logic [tkcd_pkg::TS_W-1:0] stamp;
    for (int i = 0; i < count; i++) begin
      a = gen_a;
      b = gen_b;
      r = $urandom_range(0, 99);
      if (r < 14) a = ~a;
      else if (r < 28) b = ~b;
      else if (r < 34) begin
        a = ~a;
        b = ~b;
      end
      case ($urandom_range(0, 9))
        0: stamp = gen_now;
        1, 2, 3, 4: stamp = gen_now + $urandom_range(1, w / 2 + 1);
        5, 6, 7: stamp = gen_now + $urandom_range(w / 2, 2 * w + 2);
        8: stamp = gen_now + w - 1 + $urandom_range(0, 1);
        default: stamp = $urandom();
      endcase
      push_tick(a, b, stamp);
    end
  endtask

  // Wait until every tick has transferred and every action has come out
  task automatic drain();
    while (poll_ticks.size() != 0 || expected_actions.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(logic [tkcd_pkg::WIN_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // End the run if it has not finished by a generous limit
  initial begin
    #2_000_000;
    $display("two_key_chord_detector_top_tb NOT OK");
    $finish;
  end

  // Track transfers into the block and predict their actions
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) win_ms = cfg_wr_data;
      if (in_valid && !in_stall) begin
        expected_actions.push_back(predict_actions(in_data));
        void'(poll_ticks.pop_front());
        taken_count++;
      end
    end
  end

  // Offer the next tick once the current one has transferred
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || taken_count != seen_count) begin
      seen_count = taken_count;
      if (poll_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= poll_ticks[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel at random, or hold off for a long stretch
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (pressure_armed && !hold_done) begin
        hold_left = 40;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    tkcd_pkg::out_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_actions.size() == 0) begin
        $error("result transfer with no prediction pending: %b", out_data);
        error_count++;
      end else begin
        exp_res = expected_actions.pop_front();
        check_field("toggle_page", exp_res.toggle_page, out_data.toggle_page);
        check_field("a_press", exp_res.a_press, out_data.a_press);
        check_field("a_release", exp_res.a_release, out_data.a_release);
        check_field("b_press", exp_res.b_press, out_data.b_press);
        check_field("b_release", exp_res.b_release, out_data.b_release);
      end
    end
  end

  initial begin
    logic [tkcd_pkg::WIN_W-1:0] w;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset window: holds, taps, chords, latch, timestamp wrap
    send_idle_pct = 33;
    recv_idle_pct = 49;
    push_tick(1'b0, 1'b0, 32'd0);
    push_tick(1'b1, 1'b0, 32'd100);
    push_tick(1'b1, 1'b0, 32'd179);
    push_tick(1'b1, 1'b0, 32'd180);
    push_tick(1'b0, 1'b0, 32'd190);
    push_tick(1'b1, 1'b0, 32'd200);
    push_tick(1'b0, 1'b0, 32'd230);
    push_tick(1'b0, 1'b1, 32'd300);
    push_tick(1'b0, 1'b1, 32'd400);
    push_tick(1'b1, 1'b1, 32'd410);
    push_tick(1'b1, 1'b0, 32'd420);
    push_tick(1'b1, 1'b1, 32'd425);
    push_tick(1'b0, 1'b0, 32'd430);
    push_tick(1'b1, 1'b0, 32'd500);
    push_tick(1'b1, 1'b1, 32'd505);
    push_tick(1'b0, 1'b0, 32'd510);
    push_tick(1'b1, 1'b1, 32'd520);
    push_tick(1'b0, 1'b1, 32'd530);
    push_tick(1'b0, 1'b0, 32'd540);
    push_tick(1'b1, 1'b0, 32'hFFFF_FFF0);
    push_tick(1'b1, 1'b0, 32'h0000_003F);
    push_tick(1'b1, 1'b0, 32'h0000_0040);
    push_tick(1'b0, 1'b0, 32'hFFFF_FFFF);
    push_random_ticks(280, 32'(tkcd_pkg::WIN_RESET));
    drain();

    // Zero window: a fresh press acts at once
    write_window('0);
    push_tick(1'b0, 1'b1, 32'd10);
    push_tick(1'b0, 1'b0, 32'd11);
    push_tick(1'b1, 1'b0, 32'd12);
    push_random_ticks(150, 0);
    drain();

    // Widest window
    send_idle_pct = 49;
    recv_idle_pct = 33;
    write_window('1);
    push_tick(1'b0, 1'b0, 32'd900);
    push_tick(1'b1, 1'b0, 32'd1000);
    push_tick(1'b1, 1'b0, 32'd1000 + 32'd65534);
    push_tick(1'b1, 1'b0, 32'd1000 + 32'd65535);
    push_tick(1'b0, 1'b0, 32'd1000 + 32'd70000);
    push_random_ticks(150, 65535);
    drain();

    w = tkcd_pkg::WIN_W'($urandom());
    write_window(w);
    push_random_ticks(150, 32'(w));
    drain();

    // No idling, then a long output hold-off while ticks keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    w = tkcd_pkg::WIN_W'($urandom_range(1, 300));
    write_window(w);
    push_random_ticks(200, 32'(w));
    pressure_armed = 1'b1;
    drain();

    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("two_key_chord_detector_top_tb OK");
    end else begin
      $display("two_key_chord_detector_top_tb NOT OK");
    end
    $finish;
  end

endmodule
